FILE: hdl/tst_pkg.sv
`default_nettype none
package tst_pkg;

    localparam logic [3:0] KIND_EVENT      = 4'd0;
    localparam logic [3:0] KIND_DUPLICATE  = 4'd1;
    localparam logic [3:0] KIND_LATE       = 4'd2;
    localparam logic [3:0] KIND_REJECT     = 4'd3;
    localparam logic [3:0] KIND_FULL       = 4'd4;
    localparam logic [3:0] KIND_SILENT_SET = 4'd5;
    localparam logic [3:0] KIND_SILENT_CLR = 4'd6;
    localparam logic [3:0] KIND_HIGH_SET   = 4'd7;
    localparam logic [3:0] KIND_HIGH_CLR   = 4'd8;

    localparam logic [1:0] CFG_SILENCE    = 2'd0;
    localparam logic [1:0] CFG_WATERMARK  = 2'd1;
    localparam logic [1:0] CFG_HIGH_SET   = 2'd2;
    localparam logic [1:0] CFG_HIGH_CLEAR = 2'd3;

    localparam logic [31:0] SEQ_WRAP_HIGH = 32'hffff_fff0;
    localparam logic [31:0] SEQ_WRAP_LOW  = 32'h0000_000f;
    localparam logic [31:0] COUNT_MAX     = 32'hffff_ffff;
    localparam int          MAX_RECORDS   = 16;

    typedef struct packed {
        logic [31:0] device;
        logic        seq_known;
        logic [31:0] prev_seq;
        logic [63:0] last_time;
        logic        silent;
    } slot_t;

    typedef struct packed {
        logic [3:0]         kind;
        logic [31:0]        device;
        logic [31:0]        sequence_no;
        logic [31:0]        prior;
        logic [63:0]        stamp;
        logic [15:0]        metric;
        logic signed [35:0] value;
        logic signed [31:0] average;
        logic [31:0]        tally;
        logic               last;
    } rec_t;

endpackage
`default_nettype wire

FILE: hdl/tst_ram.sv
`default_nettype none
module tst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

FILE: hdl/tst_div.sv
`default_nettype none
module tst_div #(
    parameter int SUM_W = 37,
    parameter int CNT_W = 4
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    go,
    input  wire logic signed [SUM_W-1:0] dividend,
    input  wire logic [CNT_W-1:0]        divisor,
    output logic                         done,
    output logic [31:0]                  quotient
);
    import tst_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              neg_reg, neg_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]  dsr_reg, dsr_next;
    logic [CNT_W:0]    shifted;
    logic              bit_q;
    logic [SUM_W-1:0]  result;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        shifted   = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
        bit_q     = (shifted >= {1'b0, dsr_reg});
        if (go)
        begin
            busy_next = 1'b1;
            neg_next  = dividend[SUM_W-1];
            quo_next  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            rem_next  = '0;
            dsr_next  = divisor;
            step_next = STEP_W'(SUM_W);
        end
        else if (busy_reg)
        begin
            rem_next  = bit_q ? shifted - {1'b0, dsr_reg} : shifted;
            quo_next  = {quo_reg[SUM_W-2:0], bit_q};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        step_reg <= step_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign result   = neg_reg ? -quo_reg : quo_reg;
    assign quotient = result[31:0];
    assign done     = done_reg;
endmodule
`default_nettype wire

FILE: hdl/telemetry_sample_tracker_unit.sv
`default_nettype none
// Per-device telemetry tracker. A frame is taken when start is high and busy is low; its
// records then appear one per strobe cycle and the receiver cannot stall them. An ordinary
// frame reads and compares the slots in turn in the slot search (every slot for a new device),
// sums its window samples one at a time from the window memory, runs a bit-serial divide
// and then emits its records. A watermark frame scans every slot; a rejected metric is
// answered directly from idle. No clearing pass is needed after reset.
module telemetry_sample_tracker_unit #(
    parameter int DEVICES = 16,
    parameter int METRICS = 8,
    parameter int WINDOW  = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         frame_version,
    input  wire logic               restart,
    input  wire logic [31:0]        dev_ident,
    input  wire logic [31:0]        sequence_req,
    input  wire logic [63:0]        timestamp,
    input  wire logic [15:0]        metric,
    input  wire logic signed [31:0] sample_value,
    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output logic                    strobe,
    output logic [3:0]              kind,
    output logic [31:0]             out_device,
    output logic [31:0]             out_sequence,
    output logic [31:0]             prior_sequence,
    output logic [63:0]             out_time,
    output logic [15:0]             out_metric,
    output logic signed [35:0]      scaled_value,
    output logic signed [31:0]      window_average,
    output logic [31:0]             tally,
    output logic                    last
);
    import tst_pkg::*;

    localparam int DW    = DEVICES > 1 ? $clog2(DEVICES) : 1;
    localparam int MW    = METRICS > 1 ? $clog2(METRICS) : 1;
    localparam int CELLS = DEVICES * METRICS;
    localparam int CW    = CELLS > 1 ? $clog2(CELLS) : 1;
    localparam int WDEP  = CELLS * WINDOW;
    localparam int WW    = WDEP > 1 ? $clog2(WDEP) : 1;
    localparam int IW    = WINDOW > 1 ? $clog2(WINDOW) : 1;
    localparam int NW    = $clog2(WINDOW + 1);
    localparam int SW    = 33 + $clog2(WINDOW);
    localparam int CELL_W = 1 + NW + IW;
    localparam int RW    = $clog2(MAX_RECORDS + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SRD   = 4'd1;
    localparam logic [3:0] ST_SCMP  = 4'd2;
    localparam logic [3:0] ST_PROC  = 4'd3;
    localparam logic [3:0] ST_CELL  = 4'd4;
    localparam logic [3:0] ST_WRD   = 4'd5;
    localparam logic [3:0] ST_WACC  = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;
    localparam logic [3:0] ST_HIGH  = 4'd9;
    localparam logic [3:0] ST_WMRD  = 4'd10;
    localparam logic [3:0] ST_WMCMP = 4'd11;
    localparam logic [3:0] ST_WMEND = 4'd12;

    logic [3:0]         state_reg, state_next;
    logic [31:0]        silence_reg, silence_next;
    logic [15:0]        wm_reg, wm_next;
    logic signed [31:0] hset_reg, hset_next;
    logic signed [31:0] hclr_reg, hclr_next;
    logic [31:0]        acc_reg, acc_next;
    logic [31:0]        rej_reg, rej_next;
    logic [DEVICES-1:0] used_reg, used_next;
    logic [CELLS-1:0]   cvalid_reg, cvalid_next;
    logic               strobe_reg, strobe_next;
    rec_t               out_reg, out_next;

    logic [1:0]         ver_reg, ver_next;
    logic               rst_flag_reg, rst_flag_next;
    logic [31:0]        dev_reg, dev_next;
    logic [31:0]        seq_reg, seq_next;
    logic [63:0]        ts_reg, ts_next;
    logic [15:0]        met_reg, met_next;
    logic signed [31:0] raw_reg, raw_next;
    logic [DW-1:0]      idx_reg, idx_next;
    logic               free_reg, free_next;
    logic [DW-1:0]      fidx_reg, fidx_next;
    logic [DW-1:0]      sidx_reg, sidx_next;
    slot_t              slot_reg, slot_next;
    logic [NW-1:0]      cnt_reg, cnt_next;
    logic [IW-1:0]      nxt_reg, nxt_next;
    logic               alarm_reg, alarm_next;
    logic [IW-1:0]      i_reg, i_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic signed [31:0] avg_reg, avg_next;
    logic               hiset_reg, hiset_next;
    logic [RW-1:0]      nrec_reg, nrec_next;
    logic               pend_reg, pend_next;
    logic [31:0]        pdev_reg, pdev_next;

    logic               slot_we;
    slot_t              slot_wdata;
    slot_t              slot_rdata;
    logic               cell_we;
    logic [CELL_W-1:0]  cell_wdata;
    logic [CELL_W-1:0]  cell_rdata;
    logic               win_we;
    logic [WW-1:0]      win_waddr;
    logic [31:0]        win_wdata;
    logic [31:0]        win_rdata;
    logic [CW-1:0]      cell_addr;
    logic [WW-1:0]      win_base;
    logic signed [35:0] raw_ext;
    logic signed [35:0] norm;
    logic               div_go;
    logic               div_done;
    logic [31:0]        div_q;

    logic               cur_alarm;
    logic [NW-1:0]      cur_cnt;
    logic [IW-1:0]      cur_nxt;
    logic [NW-1:0]      new_cnt;
    logic [IW-1:0]      new_nxt;
    logic               free_now;
    logic [DW-1:0]      free_sel;
    logic [63:0]        gap;
    logic               silent_hit;
    logic               set_hit;
    logic               clr_hit;
    logic [31:0]        acc_inc;
    logic [CW-1:0]      clr_base;

    assign cell_addr = CW'(sidx_reg) * CW'(METRICS) + CW'(met_reg[MW-1:0]);
    assign win_base  = WW'(cell_addr) * WW'(WINDOW);
    assign raw_ext   = 36'(raw_reg);
    assign norm      = (ver_reg == 2'd2) ? (raw_ext <<< 3) + (raw_ext <<< 1) : raw_ext;
    assign {cur_alarm, cur_cnt, cur_nxt} = cvalid_reg[cell_addr] ? cell_rdata : '0;
    assign new_cnt   = (cur_cnt < NW'(WINDOW)) ? cur_cnt + 1'b1 : cur_cnt;
    assign new_nxt   = (cur_nxt == IW'(WINDOW - 1)) ? '0 : cur_nxt + 1'b1;
    assign free_now  = free_reg || !used_reg[idx_reg];
    assign free_sel  = free_reg ? fidx_reg : idx_reg;
    assign gap       = ts_reg - slot_rdata.last_time;
    assign silent_hit = used_reg[idx_reg] && (slot_rdata.last_time != 64'd0)
                     && (ts_reg > slot_rdata.last_time) && (gap > {32'd0, silence_reg})
                     && !slot_rdata.silent && (nrec_reg < RW'(MAX_RECORDS));
    assign set_hit   = (avg_reg > hset_reg) && !alarm_reg;
    assign clr_hit   = (avg_reg <= hclr_reg) && alarm_reg;
    assign acc_inc   = (acc_reg != COUNT_MAX) ? acc_reg + 1'b1 : acc_reg;

    always_comb
    begin
        state_next    = state_reg;
        silence_next  = silence_reg;
        wm_next       = wm_reg;
        hset_next     = hset_reg;
        hclr_next     = hclr_reg;
        acc_next      = acc_reg;
        rej_next      = rej_reg;
        used_next     = used_reg;
        cvalid_next   = cvalid_reg;
        strobe_next   = 1'b0;
        out_next      = '0;
        ver_next      = ver_reg;
        rst_flag_next = rst_flag_reg;
        dev_next      = dev_reg;
        seq_next      = seq_reg;
        ts_next       = ts_reg;
        met_next      = met_reg;
        raw_next      = raw_reg;
        idx_next      = idx_reg;
        free_next     = free_reg;
        fidx_next     = fidx_reg;
        sidx_next     = sidx_reg;
        slot_next     = slot_reg;
        cnt_next      = cnt_reg;
        nxt_next      = nxt_reg;
        alarm_next    = alarm_reg;
        i_next        = i_reg;
        sum_next      = sum_reg;
        avg_next      = avg_reg;
        hiset_next    = hiset_reg;
        nrec_next     = nrec_reg;
        pend_next     = pend_reg;
        pdev_next     = pdev_reg;
        slot_we       = 1'b0;
        slot_wdata    = slot_rdata;
        cell_we       = 1'b0;
        cell_wdata    = {alarm_reg, cnt_reg, nxt_reg};
        win_we        = 1'b0;
        win_waddr     = win_base + WW'(cur_nxt);
        win_wdata     = norm[31:0];
        div_go        = 1'b0;
        clr_base      = CW'(sidx_reg) * CW'(METRICS);

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SILENCE:    silence_next = cfg_data;
                CFG_WATERMARK:  wm_next = cfg_data[15:0];
                CFG_HIGH_SET:   hset_next = cfg_data;
                CFG_HIGH_CLEAR: hclr_next = cfg_data;
                default:        silence_next = silence_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ver_next      = frame_version;
                    rst_flag_next = restart;
                    dev_next      = dev_ident;
                    seq_next      = sequence_req;
                    ts_next       = timestamp;
                    met_next      = metric;
                    raw_next      = sample_value;
                    idx_next      = '0;
                    free_next     = 1'b0;
                    nrec_next     = '0;
                    pend_next     = 1'b0;
                    if (metric == wm_reg)
                    begin
                        state_next = ST_WMRD;
                    end
                    else if (32'(metric) >= 32'(METRICS))
                    begin
                        rej_next        = (rej_reg != COUNT_MAX) ? rej_reg + 1'b1 : rej_reg;
                        strobe_next     = 1'b1;
                        out_next.kind   = KIND_REJECT;
                        out_next.device = dev_ident;
                        out_next.tally  = rej_next;
                        out_next.last   = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_SRD;
                    end
                end
            end
            ST_SRD:
            begin
                state_next = ST_SCMP;
            end
            ST_SCMP:
            begin
                if (used_reg[idx_reg] && slot_rdata.device == dev_reg)
                begin
                    sidx_next  = idx_reg;
                    slot_next  = slot_rdata;
                    state_next = ST_PROC;
                end
                else if (idx_reg == DW'(DEVICES - 1))
                begin
                    if (free_now)
                    begin
                        sidx_next           = free_sel;
                        slot_next           = '0;
                        slot_next.device    = dev_reg;
                        used_next[free_sel] = 1'b1;
                        clr_base            = CW'(free_sel) * CW'(METRICS);
                        for (int m = 0; m < METRICS; m++)
                        begin
                            cvalid_next[clr_base + CW'(m)] = 1'b0;
                        end
                        state_next = ST_PROC;
                    end
                    else
                    begin
                        strobe_next     = 1'b1;
                        out_next.kind   = KIND_FULL;
                        out_next.device = dev_reg;
                        out_next.last   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    if (!free_reg && !used_reg[idx_reg])
                    begin
                        free_next = 1'b1;
                        fidx_next = idx_reg;
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SRD;
                end
            end
            ST_PROC:
            begin
                if (slot_reg.seq_known && !rst_flag_reg && seq_reg == slot_reg.prev_seq)
                begin
                    strobe_next          = 1'b1;
                    out_next.kind        = KIND_DUPLICATE;
                    out_next.device      = dev_reg;
                    out_next.sequence_no = seq_reg;
                    out_next.last        = 1'b1;
                    state_next           = ST_IDLE;
                end
                else if (slot_reg.seq_known && !rst_flag_reg
                         && !(slot_reg.prev_seq >= SEQ_WRAP_HIGH && seq_reg <= SEQ_WRAP_LOW)
                         && seq_reg < slot_reg.prev_seq)
                begin
                    strobe_next          = 1'b1;
                    out_next.kind        = KIND_LATE;
                    out_next.device      = dev_reg;
                    out_next.sequence_no = seq_reg;
                    out_next.prior       = slot_reg.prev_seq;
                    out_next.last        = 1'b1;
                    state_next           = ST_IDLE;
                end
                else
                begin
                    if (rst_flag_reg)
                    begin
                        for (int m = 0; m < METRICS; m++)
                        begin
                            cvalid_next[clr_base + CW'(m)] = 1'b0;
                        end
                    end
                    if (slot_reg.silent)
                    begin
                        strobe_next     = 1'b1;
                        out_next.kind   = KIND_SILENT_CLR;
                        out_next.device = dev_reg;
                    end
                    slot_we              = 1'b1;
                    slot_wdata.device    = dev_reg;
                    slot_wdata.seq_known = 1'b1;
                    slot_wdata.prev_seq  = seq_reg;
                    slot_wdata.last_time = ts_reg;
                    slot_wdata.silent    = 1'b0;
                    state_next           = ST_CELL;
                end
            end
            ST_CELL:
            begin
                win_we                 = 1'b1;
                cell_we                = 1'b1;
                cell_wdata             = {cur_alarm, new_cnt, new_nxt};
                cvalid_next[cell_addr] = 1'b1;
                cnt_next               = new_cnt;
                nxt_next               = new_nxt;
                alarm_next             = cur_alarm;
                i_next                 = '0;
                sum_next               = '0;
                state_next             = ST_WRD;
            end
            ST_WRD:
            begin
                state_next = ST_WACC;
            end
            ST_WACC:
            begin
                sum_next = sum_reg + SW'($signed(win_rdata));
                i_next   = i_reg + 1'b1;
                if (NW'(i_reg) + 1'b1 == cnt_reg)
                begin
                    div_go     = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_WRD;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    avg_next   = div_q;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                acc_next             = acc_inc;
                strobe_next          = 1'b1;
                out_next.kind        = KIND_EVENT;
                out_next.device      = dev_reg;
                out_next.sequence_no = seq_reg;
                out_next.stamp       = ts_reg;
                out_next.metric      = met_reg;
                out_next.value       = norm;
                out_next.average     = avg_reg;
                out_next.tally       = acc_inc;
                out_next.last        = !(set_hit || clr_hit);
                hiset_next           = set_hit;
                if (set_hit || clr_hit)
                begin
                    cell_we    = 1'b1;
                    cell_wdata = {!alarm_reg, cnt_reg, nxt_reg};
                    state_next = ST_HIGH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_HIGH:
            begin
                strobe_next      = 1'b1;
                out_next.kind    = hiset_reg ? KIND_HIGH_SET : KIND_HIGH_CLR;
                out_next.device  = dev_reg;
                out_next.metric  = met_reg;
                out_next.average = avg_reg;
                out_next.last    = 1'b1;
                state_next       = ST_IDLE;
            end
            ST_WMRD:
            begin
                state_next = ST_WMCMP;
            end
            ST_WMCMP:
            begin
                if (silent_hit)
                begin
                    slot_we           = 1'b1;
                    slot_wdata.silent = 1'b1;
                    if (pend_reg)
                    begin
                        strobe_next     = 1'b1;
                        out_next.kind   = KIND_SILENT_SET;
                        out_next.device = pdev_reg;
                        out_next.stamp  = ts_reg;
                    end
                    pend_next = 1'b1;
                    pdev_next = slot_rdata.device;
                    nrec_next = nrec_reg + 1'b1;
                end
                if (idx_reg == DW'(DEVICES - 1))
                begin
                    state_next = ST_WMEND;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_WMRD;
                end
            end
            ST_WMEND:
            begin
                if (pend_reg)
                begin
                    strobe_next     = 1'b1;
                    out_next.kind   = KIND_SILENT_SET;
                    out_next.device = pdev_reg;
                    out_next.stamp  = ts_reg;
                    out_next.last   = 1'b1;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            silence_reg <= 32'd5000;
            wm_reg      <= 16'hffff;
            hset_reg    <= 32'sd50000;
            hclr_reg    <= 32'sd45000;
            acc_reg     <= '0;
            rej_reg     <= '0;
            used_reg    <= '0;
            cvalid_reg  <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            silence_reg <= silence_next;
            wm_reg      <= wm_next;
            hset_reg    <= hset_next;
            hclr_reg    <= hclr_next;
            acc_reg     <= acc_next;
            rej_reg     <= rej_next;
            used_reg    <= used_next;
            cvalid_reg  <= cvalid_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg      <= out_next;
        ver_reg      <= ver_next;
        rst_flag_reg <= rst_flag_next;
        dev_reg      <= dev_next;
        seq_reg      <= seq_next;
        ts_reg       <= ts_next;
        met_reg      <= met_next;
        raw_reg      <= raw_next;
        idx_reg      <= idx_next;
        free_reg     <= free_next;
        fidx_reg     <= fidx_next;
        sidx_reg     <= sidx_next;
        slot_reg     <= slot_next;
        cnt_reg      <= cnt_next;
        nxt_reg      <= nxt_next;
        alarm_reg    <= alarm_next;
        i_reg        <= i_next;
        sum_reg      <= sum_next;
        avg_reg      <= avg_next;
        hiset_reg    <= hiset_next;
        nrec_reg     <= nrec_next;
        pend_reg     <= pend_next;
        pdev_reg     <= pdev_next;
    end

    // slot records, searched one entry per read
    tst_ram #(
        .WIDTH($bits(slot_t)),
        .DEPTH(DEVICES)
    ) u_slot_ram (
        .clk  (clk),
        .we   (slot_we),
        .waddr((state_reg == ST_PROC) ? sidx_reg : idx_reg),
        .wdata(slot_wdata),
        .raddr(idx_reg),
        .rdata(slot_rdata)
    );

    // per-cell window position, fill and alarm
    tst_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELLS)
    ) u_cell_ram (
        .clk  (clk),
        .we   (cell_we),
        .waddr(cell_addr),
        .wdata(cell_wdata),
        .raddr(cell_addr),
        .rdata(cell_rdata)
    );

    tst_ram #(
        .WIDTH(32),
        .DEPTH(WDEP)
    ) u_win_ram (
        .clk  (clk),
        .we   (win_we),
        .waddr(win_waddr),
        .wdata(win_wdata),
        .raddr(win_base + WW'(i_reg)),
        .rdata(win_rdata)
    );

    tst_div #(
        .SUM_W(SW),
        .CNT_W(NW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (div_go),
        .dividend(sum_next),
        .divisor (cnt_reg),
        .done    (div_done),
        .quotient(div_q)
    );

    assign busy           = (state_reg != ST_IDLE);
    assign strobe         = strobe_reg;
    assign kind           = out_reg.kind;
    assign out_device     = out_reg.device;
    assign out_sequence   = out_reg.sequence_no;
    assign prior_sequence = out_reg.prior;
    assign out_time       = out_reg.stamp;
    assign out_metric     = out_reg.metric;
    assign scaled_value   = out_reg.value;
    assign window_average = out_reg.average;
    assign tally          = out_reg.tally;
    assign last           = out_reg.last;
endmodule
`default_nettype wire

FILE: tb/telemetry_sample_tracker_checker.sv
module telemetry_sample_tracker_checker (
    input  wire logic               clk,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [1:0]         frame_version,
    input  wire logic               restart,
    input  wire logic [31:0]        dev_ident,
    input  wire logic [31:0]        sequence_req,
    input  wire logic [63:0]        timestamp,
    input  wire logic [15:0]        metric,
    input  wire logic signed [31:0] sample_value,
    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               strobe,
    input  wire logic [3:0]         kind,
    input  wire logic [31:0]        out_device,
    input  wire logic [31:0]        out_sequence,
    input  wire logic [31:0]        prior_sequence,
    input  wire logic [63:0]        out_time,
    input  wire logic [15:0]        out_metric,
    input  wire logic signed [35:0] scaled_value,
    input  wire logic signed [31:0] window_average,
    input  wire logic [31:0]        tally,
    input  wire logic               last,
    output int                      fail_count,
    output int                      records_left,
    output int                      records_seen
);
    import tst_pkg::*;

    localparam int DEVS = 16;
    localparam int NMET = 8;
    localparam int WIN  = 8;

    logic [31:0]        silence_limit;
    logic [15:0]        wm_code;
    logic signed [31:0] set_level;
    logic signed [31:0] clear_level;

    bit          used [DEVS];
    logic [31:0] slot_id [DEVS];
    bit          seq_ok [DEVS];
    logic [31:0] prev_seq [DEVS];
    logic [63:0] last_ts [DEVS];
    bit          silent [DEVS];
    int          samples [DEVS*NMET][WIN];
    int          wr_ptr [DEVS*NMET];
    int          fill [DEVS*NMET];
    bit          alarm [DEVS*NMET];
    logic [31:0] accepted_cnt;
    logic [31:0] rejected_cnt;

    rec_t expected_recs[$];

    initial
    begin
        silence_limit = 32'd5000;
        wm_code       = 16'hffff;
        set_level     = 50000;
        clear_level   = 45000;
        accepted_cnt  = '0;
        rejected_cnt  = '0;
        fail_count    = 0;
        records_seen  = 0;
        for (int s = 0; s < DEVS; s++)
        begin
            used[s] = 0;
            slot_id[s] = '0;
            seq_ok[s] = 0;
            prev_seq[s] = '0;
            last_ts[s] = '0;
            silent[s] = 0;
        end
        for (int c = 0; c < DEVS*NMET; c++)
        begin
            wr_ptr[c] = 0;
            fill[c] = 0;
            alarm[c] = 0;
            for (int i = 0; i < WIN; i++)
                samples[c][i] = 0;
        end
    end

    assign records_left = expected_recs.size();

    function automatic rec_t blank_rec(logic [3:0] k, logic [31:0] dev);
        rec_t r;
        r = '0;
        r.kind = k;
        r.device = dev;
        return r;
    endfunction

    function automatic void clear_cells(int s);
        for (int m = 0; m < NMET; m++)
        begin
            wr_ptr[s*NMET+m] = 0;
            fill[s*NMET+m] = 0;
            alarm[s*NMET+m] = 0;
            for (int i = 0; i < WIN; i++)
                samples[s*NMET+m][i] = 0;
        end
    endfunction

    task automatic predict_records();
        rec_t        recs[$];
        rec_t        r;
        int          hit;
        int          open_slot;
        int          cidx;
        longint      scaled;
        longint      sum;
        longint      avg;
        logic [31:0] dev;
        logic [31:0] sq;
        begin
            hit = -1;
            open_slot = -1;
            dev = dev_ident;
            sq = sequence_req;
            scaled = (frame_version == 2'd2) ? longint'(sample_value) * 10
                                             : longint'(sample_value);
            if (metric == wm_code)
            begin
                for (int s = 0; s < DEVS && recs.size() < MAX_RECORDS; s++)
                begin
                    if (!used[s] || last_ts[s] == 0)
                        continue;
                    if (timestamp > last_ts[s] && timestamp - last_ts[s] > {32'd0, silence_limit}
                        && !silent[s])
                    begin
                        silent[s] = 1;
                        r = blank_rec(KIND_SILENT_SET, slot_id[s]);
                        r.stamp = timestamp;
                        recs.push_back(r);
                    end
                end
            end
            else if (metric >= NMET)
            begin
                if (rejected_cnt != COUNT_MAX)
                    rejected_cnt++;
                r = blank_rec(KIND_REJECT, dev);
                r.tally = rejected_cnt;
                recs.push_back(r);
            end
            else
            begin
                for (int s = 0; s < DEVS; s++)
                begin
                    if (used[s] && slot_id[s] == dev)
                    begin
                        hit = s;
                        break;
                    end
                    if (!used[s] && open_slot < 0)
                        open_slot = s;
                end
                if (hit < 0 && open_slot < 0)
                    recs.push_back(blank_rec(KIND_FULL, dev));
                else
                begin
                    if (hit < 0)
                    begin
                        hit = open_slot;
                        used[hit] = 1;
                        slot_id[hit] = dev;
                        seq_ok[hit] = 0;
                        prev_seq[hit] = '0;
                        last_ts[hit] = '0;
                        silent[hit] = 0;
                        clear_cells(hit);
                    end
                    if (restart)
                    begin
                        seq_ok[hit] = 0;
                        clear_cells(hit);
                    end
                    if (seq_ok[hit] && sq == prev_seq[hit])
                    begin
                        r = blank_rec(KIND_DUPLICATE, dev);
                        r.sequence_no = sq;
                        recs.push_back(r);
                    end
                    else if (seq_ok[hit] && sq < prev_seq[hit]
                             && !(prev_seq[hit] >= SEQ_WRAP_HIGH && sq <= SEQ_WRAP_LOW))
                    begin
                        r = blank_rec(KIND_LATE, dev);
                        r.sequence_no = sq;
                        r.prior = prev_seq[hit];
                        recs.push_back(r);
                    end
                    else
                    begin
                        if (silent[hit])
                        begin
                            silent[hit] = 0;
                            recs.push_back(blank_rec(KIND_SILENT_CLR, dev));
                        end
                        seq_ok[hit] = 1;
                        prev_seq[hit] = sq;
                        last_ts[hit] = timestamp;
                        cidx = hit * NMET + int'(metric);
                        samples[cidx][wr_ptr[cidx]] = int'(scaled[31:0]);
                        wr_ptr[cidx] = (wr_ptr[cidx] + 1) % WIN;
                        if (fill[cidx] < WIN)
                            fill[cidx]++;
                        sum = 0;
                        for (int i = 0; i < fill[cidx]; i++)
                            sum += samples[cidx][i];
                        avg = sum / longint'(fill[cidx]);
                        if (accepted_cnt != COUNT_MAX)
                            accepted_cnt++;
                        r = blank_rec(KIND_EVENT, dev);
                        r.sequence_no = sq;
                        r.stamp = timestamp;
                        r.metric = metric;
                        r.value = scaled[35:0];
                        r.average = avg[31:0];
                        r.tally = accepted_cnt;
                        recs.push_back(r);
                        if (avg > longint'(set_level) && !alarm[cidx])
                        begin
                            alarm[cidx] = 1;
                            r = blank_rec(KIND_HIGH_SET, dev);
                            r.metric = metric;
                            r.average = avg[31:0];
                            recs.push_back(r);
                        end
                        else if (avg <= longint'(clear_level) && alarm[cidx])
                        begin
                            alarm[cidx] = 0;
                            r = blank_rec(KIND_HIGH_CLR, dev);
                            r.metric = metric;
                            r.average = avg[31:0];
                            recs.push_back(r);
                        end
                    end
                end
            end
            if (recs.size() > 0)
                recs[recs.size()-1].last = 1;
            foreach (recs[i])
                expected_recs.push_back(recs[i]);
        end
    endtask

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        begin
            $display("mismatch at record %0d: %s got %0h expected %0h",
                     records_seen, field, got, want);
            fail_count++;
        end
    endtask

    task automatic compare_record();
        rec_t want;
        begin
            if (expected_recs.size() == 0)
            begin
                report_mismatch("kind of record with none pending", 64'(kind), 64'(0));
            end
            else
            begin
                want = expected_recs.pop_front();
                if (kind !== want.kind)
                    report_mismatch("kind", 64'(kind), 64'(want.kind));
                if (out_device !== want.device)
                    report_mismatch("out_device", 64'(out_device), 64'(want.device));
                if (out_sequence !== want.sequence_no)
                    report_mismatch("out_sequence", 64'(out_sequence), 64'(want.sequence_no));
                if (prior_sequence !== want.prior)
                    report_mismatch("prior_sequence", 64'(prior_sequence), 64'(want.prior));
                if (out_time !== want.stamp)
                    report_mismatch("out_time", out_time, want.stamp);
                if (out_metric !== want.metric)
                    report_mismatch("out_metric", 64'(out_metric), 64'(want.metric));
                if (scaled_value !== want.value)
                    report_mismatch("scaled_value", 64'(unsigned'(scaled_value)),
                                    64'(unsigned'(want.value)));
                if (window_average !== want.average)
                    report_mismatch("window_average", 64'(unsigned'(window_average)),
                                    64'(unsigned'(want.average)));
                if (tally !== want.tally)
                    report_mismatch("tally", 64'(tally), 64'(want.tally));
                if (last !== want.last)
                    report_mismatch("last", 64'(last), 64'(want.last));
            end
            records_seen++;
        end
    endtask

    always @(posedge clk)
    begin
        if (strobe === 1'b1)
            compare_record();
        if (cfg_write === 1'b1)
        begin
            case (cfg_index)
                CFG_SILENCE:    silence_limit = cfg_data;
                CFG_WATERMARK:  wm_code = cfg_data[15:0];
                CFG_HIGH_SET:   set_level = cfg_data;
                CFG_HIGH_CLEAR: clear_level = cfg_data;
                default:        ;
            endcase
        end
        if (start === 1'b1 && busy === 1'b0)
            predict_records();
    end

endmodule

FILE: tb/tb_telemetry_sample_tracker_unit.sv
module tb_telemetry_sample_tracker_unit;
    import tst_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int POOL        = 14;
    localparam int DRAIN_WAIT  = 120;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         frame_version;
    logic               restart;
    logic [31:0]        dev_ident;
    logic [31:0]        sequence_req;
    logic [63:0]        timestamp;
    logic [15:0]        metric;
    logic signed [31:0] sample_value;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               strobe;
    logic [3:0]         kind;
    logic [31:0]        out_device;
    logic [31:0]        out_sequence;
    logic [31:0]        prior_sequence;
    logic [63:0]        out_time;
    logic [15:0]        out_metric;
    logic signed [35:0] scaled_value;
    logic signed [31:0] window_average;
    logic [31:0]        tally;
    logic               last;

    int fail_count;
    int records_left;
    int records_seen;
    int frames_sent;
    int idle_cycles;
    int send_gap_pct;

    logic [31:0] pool_id [POOL];
    logic [31:0] pool_seq [POOL];
    logic [63:0] clock_ms;
    logic [15:0] wm_metric;

    telemetry_sample_tracker_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .frame_version(frame_version), .restart(restart), .dev_ident(dev_ident),
        .sequence_req(sequence_req), .timestamp(timestamp), .metric(metric),
        .sample_value(sample_value), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .strobe(strobe), .kind(kind), .out_device(out_device),
        .out_sequence(out_sequence), .prior_sequence(prior_sequence), .out_time(out_time),
        .out_metric(out_metric), .scaled_value(scaled_value), .window_average(window_average),
        .tally(tally), .last(last)
    );

    telemetry_sample_tracker_checker checker_i (
        .clk(clk), .start(start), .busy(busy),
        .frame_version(frame_version), .restart(restart), .dev_ident(dev_ident),
        .sequence_req(sequence_req), .timestamp(timestamp), .metric(metric),
        .sample_value(sample_value), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .strobe(strobe), .kind(kind), .out_device(out_device),
        .out_sequence(out_sequence), .prior_sequence(prior_sequence), .out_time(out_time),
        .out_metric(out_metric), .scaled_value(scaled_value), .window_average(window_average),
        .tally(tally), .last(last), .fail_count(fail_count), .records_left(records_left),
        .records_seen(records_seen)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // watchdog on cycles with no beat in either direction
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", idle_cycles);
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_frame(logic [1:0] ver, logic rs, logic [31:0] dev, logic [31:0] sq,
                              logic [63:0] ts, logic [15:0] met, logic [31:0] raw);
        int gap;
        begin
            @(negedge clk);
            frame_version = ver;
            restart = rs;
            dev_ident = dev;
            sequence_req = sq;
            timestamp = ts;
            metric = met;
            sample_value = raw;
            start = 1;
            forever
            begin
                @(posedge clk);
                if (!busy)
                    break;
            end
            frames_sent++;
            if ($urandom_range(99) < send_gap_pct)
            begin
                gap = $urandom_range(20, 1);
                @(negedge clk);
                start = 0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        begin
            @(negedge clk);
            cfg_write = 1;
            cfg_index = idx;
            cfg_data = data;
            @(posedge clk);
        end
    endtask

    task automatic settle();
        begin
            @(negedge clk);
            start = 0;
            cfg_write = 0;
            wait (records_left == 0);
            repeat (DRAIN_WAIT) @(posedge clk);
        end
    endtask

    task automatic set_phase(logic [31:0] lim, logic [15:0] wm, logic [31:0] hs,
                             logic [31:0] hc);
        begin
            settle();
            write_reg(CFG_SILENCE, lim);
            write_reg(CFG_WATERMARK, {16'd0, wm});
            write_reg(CFG_HIGH_SET, hs);
            write_reg(CFG_HIGH_CLEAR, hc);
            @(negedge clk);
            cfg_write = 0;
            wm_metric = wm;
        end
    endtask

    // traffic mostly on the device pool, with watermark frames, stray devices and occasional broken frames
    task automatic random_frames(int count);
        int          p;
        int          pick;
        logic [1:0]  ver;
        logic [31:0] sq;
        logic [31:0] raw;
        logic [15:0] met;
        logic [63:0] ts;
        begin
            repeat (count)
            begin
                p = $urandom_range(POOL - 1);
                pick = $urandom_range(99);
                clock_ms = clock_ms + 64'($urandom_range(3000, 1));
                ver = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'($urandom_range(2, 1));
                if (ver == 2'd2)
                    raw = $urandom_range(6500, 3500);
                else
                    raw = $urandom_range(65000, 35000);
                if ($urandom_range(9) == 0)
                    raw = $urandom;
                met = 16'($urandom_range(7));
                ts = clock_ms;
                if (pick < 12)
                begin
                    ts = ($urandom_range(3) == 0) ? {$urandom, $urandom}
                                                   : clock_ms + 64'($urandom_range(12000));
                    send_frame(ver, 1'b0, $urandom, $urandom, ts, wm_metric, raw);
                end
                else if (pick < 16)
                    send_frame(ver, 1'($urandom_range(1)), $urandom, $urandom, ts,
                               16'($urandom), raw);
                else if (pick < 20)
                    send_frame(ver, 1'b0, $urandom, $urandom, ts, met, raw);
                else
                begin
                    sq = pool_seq[p] + $urandom_range(3, 1);
                    if (pick < 26)
                        sq = pool_seq[p];
                    else if (pick < 31)
                        sq = pool_seq[p] - $urandom_range(5, 1);
                    else if (pick < 33)
                        sq = $urandom_range(15);
                    send_frame(ver, $urandom_range(29) == 0, pool_id[p], sq, ts, met, raw);
                    if (sq > pool_seq[p] || pick < 33)
                        pool_seq[p] = sq;
                end
            end
        end
    endtask

    initial
    begin
        rst_n = 0;
        start = 0;
        cfg_write = 0;
        cfg_index = '0;
        cfg_data = '0;
        frame_version = '0;
        restart = 0;
        dev_ident = '0;
        sequence_req = '0;
        timestamp = '0;
        metric = '0;
        sample_value = '0;
        frames_sent = 0;
        idle_cycles = 0;
        send_gap_pct = 12;
        clock_ms = 64'd1000;
        wm_metric = 16'hffff;
        for (int i = 0; i < POOL; i++)
        begin
            pool_id[i] = $urandom;
            pool_seq[i] = $urandom_range(1000);
        end
        pool_seq[0] = 32'hffff_fff8;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        set_phase(32'd5000, 16'hffff, 32'd50000, 32'd45000);
        send_frame(2'd1, 1'b0, 32'd0, 32'd0, 64'd0, 16'd0, 32'h7fff_ffff);
        send_frame(2'd2, 1'b0, 32'hffff_ffff, 32'hffff_fffe, 64'hffff_ffff_ffff_fff0, 16'd7,
                   32'h8000_0000);
        send_frame(2'd2, 1'b0, 32'hffff_ffff, 32'h0000_0003, 64'd20, 16'd7, 32'h7fff_ffff);
        send_frame(2'd1, 1'b0, 32'hffff_ffff, 32'h0000_0003, 64'd21, 16'd7, 32'd1);
        send_frame(2'd1, 1'b0, 32'hffff_ffff, 32'h0000_0001, 64'd22, 16'd7, 32'd1);
        send_frame(2'd1, 1'b1, 32'hffff_ffff, 32'h0000_0001, 64'd23, 16'd6, 32'hffff_ffff);
        send_frame(2'd0, 1'b0, 32'd0, 32'd5, 64'd100, 16'd3, 32'd60000);
        send_frame(2'd3, 1'b0, 32'd0, 32'd6, 64'd200, 16'd3, 32'd60000);
        send_frame(2'd1, 1'b0, 32'd0, 32'd7, 64'd300, 16'd3, 32'hffff_0000);
        send_frame(2'd1, 1'b0, 32'd5, 32'd0, 64'd0, 16'd8, 32'd0);
        send_frame(2'd1, 1'b0, 32'd5, 32'd0, 64'd0, 16'hfffe, 32'd0);
        send_frame(2'd1, 1'b0, 32'd0, 32'd0, 64'd200, 16'hffff, 32'd0);
        send_frame(2'd1, 1'b0, 32'd0, 32'd0, 64'd6000, 16'hffff, 32'd0);
        send_frame(2'd1, 1'b0, 32'd0, 32'd8, 64'd7000, 16'd3, 32'd1);
        send_frame(2'd1, 1'b0, 32'd0, 32'd0, 64'hffff_ffff_ffff_ffff, 16'hffff, 32'd0);
        for (int i = 0; i < 17; i++)
            send_frame(2'd1, 1'b0, 32'h1000 + i, 32'd1, 64'd500, 16'd1, 32'd10);
        random_frames(20);

        set_phase(32'd0, 16'd7, 32'h8000_0000, 32'h7fff_ffff);
        send_gap_pct = 82;
        random_frames(30);

        set_phase(32'hffff_ffff, 16'h00ab, 32'h7fff_ffff, 32'h8000_0000);
        send_gap_pct = 0;
        random_frames(20);
        set_phase(32'd2000, 16'hffff, 32'd50000, 32'd45000);
        random_frames(20);

        settle();
        $display("sent %0d frames, checked %0d records", frames_sent, records_seen);
        $display("covered rejects, table full, duplicates, late and wrapped sequences, alarms");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/tst_pkg.sv
hdl/tst_ram.sv
hdl/tst_div.sv
hdl/telemetry_sample_tracker_unit.sv
tb/telemetry_sample_tracker_checker.sv
tb/tb_telemetry_sample_tracker_unit.sv
